/* hw/rtl/pse_pkg.sv */
// pse_pkg: shared types and codes of the postfix stack evaluator
// depends on nothing
`timescale 1ns / 1ps
package pse_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_EXT_W = 6;

  localparam logic [1:0] CMD_VAR = 2'd0;
  localparam logic [1:0] CMD_OP  = 2'd1;
  localparam logic [1:0] CMD_END = 2'd2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_DIVZ  = 3'd2;
  localparam logic [2:0] ST_MODZ  = 3'd3;
  localparam logic [2:0] ST_BADOP = 3'd4;
  localparam logic [2:0] ST_OVER  = 3'd5;
  localparam logic [2:0] ST_LEFT  = 3'd6;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage

/* hw/rtl/postfix_stack_evaluator_top.sv */
// postfix_stack_evaluator_top: postfix evaluator on a shifting chain of stack cells
// depends on pse_pkg, pse_cell, pse_div
//
//   channel | signals                                        | direction
//   in      | in_valid_i in_ready_o cmd_i var_index_i        | request in
//           | var_value_i op_code_i                          |
//   out     | out_valid_o out_ready_i status_o top_value_o   | request out
//           | done_res_o                                     |
//
// results are registered; divide and modulo wait for the bit-serial
// divider (one quotient bit per cycle)
// the top of stack sits in cell 0; push and pop shift the whole chain at once
// a new request is taken only once the previous result has been taken
// reset clears count, error and seen flags; no clearing pass
`timescale 1ns / 1ps
module postfix_stack_evaluator_top import pse_pkg::*; #(
  parameter int STACK_DEPTH = 128,
  parameter int VAR_COUNT   = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [4:0]  var_index_i,
  input  logic signed [31:0] var_value_i,
  input  logic [2:0]  op_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic signed [31:0] top_value_o,
  output logic        done_res_o
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int VI_W  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [2:0]        err_q, err_d;
  logic [VAR_COUNT-1:0] seen_q, seen_d;
  logic [DATA_W-1:0] vars_q [VAR_COUNT];
  logic              var_we;
  logic [VI_W-1:0]   vidx;
  logic              vin_range;
  logic              is_mod_q, is_mod_d;

  logic              out_valid_q, out_valid_d, done_q, done_d;
  logic [2:0]        status_q, status_d;
  logic [DATA_W-1:0] top_q, top_d;

  cell_op_e          op0, op_rest;
  logic [DATA_W-1:0] new_val, val_sel, res, top_next;
  logic [DATA_W-1:0] cell_data [STACK_DEPTH];
  logic [IDX_EXT_W-1:0] idx_ext;
  logic              emit, accept;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign idx_ext   = {1'b0, var_index_i};
  assign vidx      = idx_ext[VI_W-1:0];
  assign vin_range = 32'(var_index_i) < VAR_COUNT;
  assign val_sel   = (vin_range && seen_q[vidx]) ? vars_q[vidx] : var_value_i;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] upper, lower;
      if (gi == 0) begin : g_first
        assign upper = new_val;
      end else begin : g_mid
        assign upper = cell_data[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_last
        assign lower = '0;
      end else begin : g_inner
        assign lower = cell_data[gi+1];
      end
      pse_cell u_cell (
        .clk_i   (clk_i),
        .op_i    ((gi == 0) ? op0 : op_rest),
        .upper_i (upper),
        .lower_i (lower),
        .data_o  (cell_data[gi])
      );
    end
  endgenerate

  pse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    seen_d      = seen_q;
    is_mod_d    = is_mod_q;
    var_we      = 1'b0;
    op0         = CELL_HOLD;
    op_rest     = CELL_HOLD;
    new_val     = val_sel;
    res         = '0;
    emit        = 1'b0;
    done_d      = 1'b0;
    status_d    = status_q;
    top_d       = top_q;
    div_req.start    = 1'b0;
    div_req.dividend = cell_data[1];
    div_req.divisor  = cell_data[0];
    out_valid_d = out_valid_q && !out_ready_i;

    case (op_code_i)
      OP_ADD:  res = cell_data[1] + cell_data[0];
      OP_SUB:  res = cell_data[1] - cell_data[0];
      default: res = 32'(cell_data[1] * cell_data[0]);
    endcase

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          if (cmd_i == CMD_END) begin
            done_d = 1'b1;
          end else if (err_q == ST_OK && cmd_i == CMD_VAR) begin
            if (vin_range && !seen_q[vidx]) begin
              var_we       = 1'b1;
              seen_d[vidx] = 1'b1;
            end
            if (cnt_q < CNT_W'(STACK_DEPTH)) begin
              op0     = CELL_PUSH;
              op_rest = CELL_PUSH;
              cnt_d   = cnt_q + CNT_W'(1);
            end else begin
              err_d = ST_OVER;
            end
          end else if (err_q == ST_OK && cmd_i == CMD_OP) begin
            if (cnt_q < CNT_W'(2)) begin
              err_d = ST_UNDER;
            end else if (op_code_i > OP_MOD) begin
              err_d = ST_BADOP;
            end else if (op_code_i == OP_DIV || op_code_i == OP_MOD) begin
              if (cell_data[0] == '0) begin
                err_d = (op_code_i == OP_DIV) ? ST_DIVZ : ST_MODZ;
              end else begin
                emit          = 1'b0;
                div_req.start = 1'b1;
                is_mod_d      = (op_code_i == OP_MOD);
                state_d       = S_DIV;
              end
            end else begin
              new_val = res;
              op0     = CELL_PUSH;
              op_rest = CELL_POP;
              cnt_d   = cnt_q - CNT_W'(1);
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          emit    = 1'b1;
          new_val = is_mod_q ? div_rsp.rem : div_rsp.quo;
          op0     = CELL_PUSH;
          op_rest = CELL_POP;
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    top_next = (op0 == CELL_PUSH) ? new_val : cell_data[0];

    if (emit) begin
      out_valid_d = 1'b1;
      if (done_d) begin
        top_d = '0;
        if (err_q != ST_OK) begin
          status_d = err_q;
        end else if (cnt_q == '0) begin
          status_d = ST_UNDER;
        end else if (cnt_q > CNT_W'(1)) begin
          status_d = ST_LEFT;
        end else begin
          status_d = ST_OK;
          top_d    = cell_data[0];
        end
        cnt_d  = '0;
        err_d  = ST_OK;
        seen_d = '0;
      end else begin
        status_d = err_d;
        top_d    = (err_d == ST_OK && cnt_d != '0) ? top_next : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (var_we) begin
      vars_q[vidx] <= var_value_i;
    end
    is_mod_q <= is_mod_d;
    if (emit) begin
      status_q <= status_d;
      top_q    <= top_d;
      done_q   <= done_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign top_value_o = top_q;
  assign done_res_o  = done_q;

endmodule

/* hw/rtl/pse_cell.sv */
// pse_cell: one operand stack entry, shifts toward either neighbor
// depends on pse_pkg
`timescale 1ns / 1ps
module pse_cell import pse_pkg::*; (
  input  logic              clk_i,
  input  cell_op_e          op_i,
  input  logic [DATA_W-1:0] upper_i,
  input  logic [DATA_W-1:0] lower_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_PUSH: data_d = upper_i;
      CELL_POP:  data_d = lower_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* hw/rtl/pse_div.sv */
// pse_div: signed 32-bit divider, one quotient bit per cycle, truncating
// depends on pse_pkg
`timescale 1ns / 1ps
module pse_div import pse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d, done_q, done_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [DATA_W-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic              nq_q, nq_d, nr_q, nr_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign abs_a = req_i.dividend[DATA_W-1] ? -req_i.dividend : req_i.dividend;
  assign abs_b = req_i.divisor[DATA_W-1] ? -req_i.divisor : req_i.divisor;
  assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    nq_d   = nq_q;
    nr_d   = nr_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 6'(DATA_W);
      quo_d  = abs_a;
      rem_d  = '0;
      dvs_d  = abs_b;
      nq_d   = req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
      nr_d   = req_i.dividend[DATA_W-1];
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    nq_q  <= nq_d;
    nr_q  <= nr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = nq_q ? -quo_q : quo_q;
  assign rsp_o.rem  = nr_q ? -rem_q : rem_q;

endmodule

/* hw/rtl/pse_checker.sv */
// pse_props: port-level checks of the postfix stack evaluator, bound to the top
// depends on pse_pkg, postfix_stack_evaluator_top
`timescale 1ns / 1ps
module pse_props import pse_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] top_value_o,
  input logic        done_res_o
);

  // result holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(top_value_o))
    else $error("stalled result changed");

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // end request answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_END |=> out_valid_o && done_res_o)
    else $error("end request not answered");

  // failed status carries zero top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> top_value_o == '0)
    else $error("error result with nonzero top");

endmodule

bind postfix_stack_evaluator_top pse_props u_pse_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .top_value_o (top_value_o),
  .done_res_o  (done_res_o)
);
